// ===== design/lbs_pkg.sv =====
// shared constants, types and helpers of the leaky-bucket shaper
// no dependencies; imported by every module of the block
`default_nettype none

package lbs_pkg;

   // queue geometry and tag width
   localparam int QUEUE_DEPTH = 64;
   localparam int TAG_BITS    = 32;
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

   // register field widths
   localparam int LIMIT_BITS     = 7;
   localparam int INTERVAL_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CMP_BITS       = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUEUE_LIMIT    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INTERVAL_TICKS = 2'd1;

   // register reset values
   localparam logic [LIMIT_BITS-1:0]    QUEUE_LIMIT_RESET = 7'd64;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET    = 16'd1;

   // input word kinds and result event codes
   localparam logic KIND_ARRIVAL   = 1'b0;
   localparam logic KIND_TICK      = 1'b1;
   localparam logic EVENT_DISPATCH = 1'b0;
   localparam logic EVENT_DROP     = 1'b1;

   typedef logic [IDX_BITS-1:0] idx_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic push;
      logic drop;
      logic pop;
      logic load_cd;
      logic dec_cd;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic has_room;
      logic cd_expire;
      logic queue_empty;
   } status_type;

   // circular index advance
   function automatic idx_type next_slot(idx_type i);
      if (i == idx_type'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return i + idx_type'(1);
   endfunction

endpackage

`default_nettype wire

// ===== design/leaky_bucket_shaper_core.sv =====
// top level of the leaky-bucket shaper: controller plus datapath
// depends on lbs_pkg, lbs_ctrl, lbs_datapath
`default_nettype none

// Leaky-bucket shaper. Each word taken on start is a packet arrival (tag queued in a
// 64-entry fifo, or dropped when the queue is at its limit) or one time tick that runs
// the dispatch countdown. A word is taken in every cycle: busy stays low, since each
// word needs at most one fifo push or pop and one countdown update, all done at the
// edge that takes it. A drop or dispatch word appears on the rsp_ ports for exactly
// one cycle, the cycle after the word that caused it, marked by rsp_valid; the
// receiver must take it then. The fifo is a memory with a registered read of the head
// entry, which is why the result word is registered. Register writes are taken at any time
// (csr_ready is always high) but should only be issued while the block is quiet.

module leaky_bucket_shaper_core (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_kind,
   input  wire logic [lbs_pkg::TAG_BITS-1:0]        req_packet_tag,
   output logic                                     rsp_valid,
   output logic                                     rsp_event_res,
   output logic [lbs_pkg::TAG_BITS-1:0]             rsp_out_tag,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [lbs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lbs_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import lbs_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   // timer state machine
   lbs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .kind   (req_kind),
      .status (status),
      .cmd    (cmd)
   );

   // fifo, countdown and result word
   lbs_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .packet_tag    (req_packet_tag),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_event_res (rsp_event_res),
      .rsp_out_tag   (rsp_out_tag)
   );

   // a dispatch only follows an accepted tick
   a_dispatch_after_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == EVENT_DISPATCH)) |->
         $past(accept && (req_kind == KIND_TICK)))
      else $error("dispatch word without a preceding tick");

   // a drop reports the tag of the arrival just taken
   a_drop_tag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == EVENT_DROP)) |->
         ($past(accept && (req_kind == KIND_ARRIVAL)) &&
          (rsp_out_tag == $past(req_packet_tag))))
      else $error("drop word does not match the arrival");

   // an arrival with no room is always reported next cycle
   a_full_drops: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_kind == KIND_ARRIVAL) && !status.has_room) |=>
         (rsp_valid && (rsp_event_res == EVENT_DROP)))
      else $error("arrival at limit not reported as drop");

   // pop is never commanded on an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> !status.queue_empty)
      else $error("pop on empty queue");

endmodule

`default_nettype wire

// ===== design/lbs_ctrl.sv =====
// controller of the leaky-bucket shaper: timer state machine and command decode
// depends on lbs_pkg
`default_nettype none

module lbs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                accept,
   input  wire logic                kind,
   input  wire lbs_pkg::status_type status,
   output lbs_pkg::cmd_type         cmd
);
   import lbs_pkg::*;

   localparam logic [0:0] ST_IDLE  = 1'b0;
   localparam logic [0:0] ST_ARMED = 1'b1;

   logic [0:0] state_ff;
   logic [0:0] state_in;

   // decode one accepted word into datapath commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      if (accept && (kind == KIND_ARRIVAL)) begin
         cmd.push = status.has_room;
         cmd.drop = !status.has_room;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (kind == KIND_ARRIVAL)) begin
               cmd.load_cd = 1'b1;
               state_in    = ST_ARMED;
            end
         end
         ST_ARMED: begin
            if (accept && (kind == KIND_TICK)) begin
               if (!status.cd_expire) begin
                  cmd.dec_cd = 1'b1;
               end else if (!status.queue_empty) begin
                  cmd.pop     = 1'b1;
                  cmd.load_cd = 1'b1;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/lbs_datapath.sv =====
// datapath of the leaky-bucket shaper: registers, tag fifo, countdown, result word
// depends on lbs_pkg
`default_nettype none

module lbs_datapath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire lbs_pkg::cmd_type                    cmd,
   input  wire logic [lbs_pkg::TAG_BITS-1:0]        packet_tag,
   input  wire logic                                csr_write,
   input  wire logic [lbs_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [lbs_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output lbs_pkg::status_type                      status,
   output logic                                     rsp_valid,
   output logic                                     rsp_event_res,
   output logic [lbs_pkg::TAG_BITS-1:0]             rsp_out_tag
);
   import lbs_pkg::*;

   logic [LIMIT_BITS-1:0]    queue_limit_ff;
   logic [INTERVAL_BITS-1:0] interval_ff;
   logic [INTERVAL_BITS-1:0] load_value;

   logic [TAG_BITS-1:0]      queue_mem [QUEUE_DEPTH];
   logic [TAG_BITS-1:0]      rd_data_ff;
   idx_type                  head_ff;
   idx_type                  tail_ff;
   logic [COUNT_BITS-1:0]    fill_ff;
   logic [INTERVAL_BITS-1:0] countdown_ff;

   logic                     rsp_valid_ff;
   logic                     rsp_event_ff;
   logic                     rsp_from_mem_ff;
   logic [TAG_BITS-1:0]      drop_tag_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         queue_limit_ff <= QUEUE_LIMIT_RESET;
         interval_ff    <= INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_QUEUE_LIMIT:    queue_limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            CSR_INTERVAL_TICKS: interval_ff    <= csr_wdata[INTERVAL_BITS-1:0];
            default: ;
         endcase
      end
   end

   // zero interval counts as one
   assign load_value = (interval_ff == '0) ? INTERVAL_BITS'(1) : interval_ff;

   // status toward the controller
   always_comb begin
      status.has_room    = (CMP_BITS'(fill_ff) < CMP_BITS'(queue_limit_ff)) &&
                           (fill_ff < COUNT_BITS'(QUEUE_DEPTH));
      status.cd_expire   = (countdown_ff <= INTERVAL_BITS'(1));
      status.queue_empty = (fill_ff == '0);
   end

   // tag storage, head entry read every cycle
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         queue_mem[tail_ff] <= packet_tag;
      end
      rd_data_ff <= queue_mem[head_ff];
   end

   // fifo pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (cmd.push) begin
            tail_ff <= next_slot(tail_ff);
            fill_ff <= fill_ff + COUNT_BITS'(1);
         end else if (cmd.pop) begin
            head_ff <= next_slot(head_ff);
            fill_ff <= fill_ff - COUNT_BITS'(1);
         end
      end
   end

   // dispatch countdown
   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= '0;
      end else if (cmd.load_cd) begin
         countdown_ff <= load_value;
      end else if (cmd.dec_cd) begin
         countdown_ff <= countdown_ff - INTERVAL_BITS'(1);
      end
   end

   // result word, shown for one cycle after the deciding edge
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.drop || cmd.pop;
      end
      rsp_event_ff    <= cmd.drop ? EVENT_DROP : EVENT_DISPATCH;
      rsp_from_mem_ff <= cmd.pop;
      drop_tag_ff     <= packet_tag;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_out_tag   = rsp_from_mem_ff ? rd_data_ff : drop_tag_ff;

endmodule

`default_nettype wire

// ===== tb/tb_leaky_bucket_shaper_core.sv =====
// self-checking testbench of leaky_bucket_shaper_core: arrivals, ticks and register writes
// depends on lbs_pkg and the leaky_bucket_shaper_core rtl; a scoreboard class predicts
// every drop and dispatch word and checks it against the rsp_ ports
`default_nettype none

module tb_leaky_bucket_shaper_core;
   import lbs_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int WORD_TARGET    = 700;
   localparam int REPORT_LIMIT   = 10;
   localparam int DRAIN_BUDGET   = 120;

   // register indexes that the block does not decode
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;

   typedef logic [TAG_BITS-1:0] tag_type;

   // one drop or dispatch word as seen on the rsp_ ports
   typedef struct packed {
      logic    code;
      tag_type out_tag;
   } shaper_event_type;

   // predicts the shaper and holds the words still owed by the block
   class bucket_scoreboard;
      tag_type                slots [QUEUE_DEPTH];
      int unsigned            head_slot;
      int unsigned            tail_slot;
      int unsigned            held;
      int unsigned            countdown;
      bit                     armed;
      logic [LIMIT_BITS-1:0]    limit_reg;
      logic [INTERVAL_BITS-1:0] interval_reg;
      shaper_event_type       owed [$];
      int unsigned            errors;

      function new();
         limit_reg    = QUEUE_LIMIT_RESET;
         interval_reg = INTERVAL_RESET;
         head_slot    = 0;
         tail_slot    = 0;
         held         = 0;
         countdown    = 0;
         armed        = 0;
         errors       = 0;
      endfunction

      function void note_error(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("%s", msg);
         end
      endfunction

      // append a word to the owed list
      function void owe_word(shaper_event_type ev);
         owed.insert(owed.size(), ev);
      endfunction

      // remove and return the oldest owed word
      function shaper_event_type next_owed();
         shaper_event_type ev;
         ev = owed[0];
         owed.delete(0);
         return ev;
      endfunction

      // zero interval reloads as one
      function int unsigned reload();
         return (interval_reg == 0) ? 1 : int'(interval_reg);
      endfunction

      // limit above depth acts as depth
      function int unsigned cap();
         return (limit_reg > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(limit_reg);
      endfunction

      // unknown indexes are ignored
      function void write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
         if (idx == CSR_QUEUE_LIMIT) begin
            limit_reg = data[LIMIT_BITS-1:0];
         end else if (idx == CSR_INTERVAL_TICKS) begin
            interval_reg = data[INTERVAL_BITS-1:0];
         end
      endfunction

      // note one accepted word and queue what it causes
      function void take_word(logic kind, tag_type tag);
         shaper_event_type ev;
         if (kind == KIND_ARRIVAL) begin
            if (held < cap()) begin
               slots[tail_slot] = tag;
               tail_slot = (tail_slot + 1) % QUEUE_DEPTH;
               held++;
            end else begin
               ev.code    = EVENT_DROP;
               ev.out_tag = tag;
               owe_word(ev);
            end
            // arrival while armed leaves the countdown alone
            if (!armed) begin
               armed     = 1;
               countdown = reload();
            end
         end else if (armed) begin
            if (countdown > 0) begin
               countdown--;
            end
            if (countdown == 0) begin
               if (held > 0) begin
                  ev.code    = EVENT_DISPATCH;
                  ev.out_tag = slots[head_slot];
                  owe_word(ev);
                  head_slot = (head_slot + 1) % QUEUE_DEPTH;
                  held--;
                  countdown = reload();
               end else begin
                  armed = 0;
               end
            end
         end
      endfunction

      // ticks needed until the timer goes idle again
      function int unsigned ticks_left();
         return armed ? countdown + held * reload() : 0;
      endfunction

      // compare one rsp_ word with the oldest owed word
      function void check_event(logic code, tag_type got_tag);
         shaper_event_type want;
         if (owed.size() == 0) begin
            note_error($sformatf("mismatch: unexpected word event=%0d tag=%h", code, got_tag));
            return;
         end
         want = next_owed();
         if (want.code !== code) begin
            note_error($sformatf("mismatch: event expected %0d got %0d (tag %h)",
                                 want.code, code, want.out_tag));
         end
         if (want.out_tag !== got_tag) begin
            note_error($sformatf("mismatch: tag expected %h got %h", want.out_tag, got_tag));
         end
      endfunction

      function void close_out();
         if (owed.size() != 0) begin
            note_error($sformatf("mismatch: %0d words never arrived", owed.size()));
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      start;
   logic                      busy;
   logic                      req_kind;
   tag_type                   req_packet_tag;
   logic                      rsp_valid;
   logic                      rsp_event_res;
   tag_type                   rsp_out_tag;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   bucket_scoreboard tracker = new();
   bit               idling_on;
   int unsigned      quiet_cycles;
   int unsigned      sent_words;

   leaky_bucket_shaper_core dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_packet_tag (req_packet_tag),
      .rsp_valid      (rsp_valid),
      .rsp_event_res  (rsp_event_res),
      .rsp_out_tag    (rsp_out_tag),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // monitor: check results first, then note the word taken at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) begin
            tracker.check_event(rsp_event_res, rsp_out_tag);
         end
         if (start && !busy) begin
            tracker.take_word(req_kind, req_packet_tag);
         end
         if (csr_valid && csr_ready) begin
            tracker.write_reg(csr_index, csr_wdata);
         end
         // watchdog on cycles with no handshake at all
         if (rsp_valid || (start && !busy) || (csr_valid && csr_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // offer one word, with random idle cycles ahead of it
   task automatic send_word(input logic kind, input tag_type tag);
      @(negedge clock);
      while (idling_on && $urandom_range(99) < 16) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start          <= 1'b1;
      req_kind       <= kind;
      req_packet_tag <= tag;
      sent_words++;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic go_quiet();
      @(negedge clock);
      start <= 1'b0;
   endtask

   // tick until the timer has emptied the queue and gone idle
   task automatic drain_timer();
      int unsigned n;
      go_quiet();
      n = tracker.ticks_left();
      repeat (n) begin
         send_word(KIND_TICK, $urandom());
      end
      go_quiet();
   endtask

   // wait until every owed word has come
   task automatic wait_settled();
      go_quiet();
      while (tracker.owed.size() != 0) begin
         @(negedge clock);
      end
      repeat (3) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(input logic [CSR_DATA_BITS-1:0] limit_data,
                           input logic [CSR_DATA_BITS-1:0] interval_data);
      wait_settled();
      write_csr(CSR_QUEUE_LIMIT, limit_data);
      write_csr(CSR_INTERVAL_TICKS, interval_data);
   endtask

   function automatic logic [CSR_DATA_BITS-1:0] pick_limit();
      logic [LIMIT_BITS-1:0] lim;
      case ($urandom_range(9))
         0:       lim = '0;
         1:       lim = LIMIT_BITS'(QUEUE_DEPTH);
         2:       lim = LIMIT_BITS'($urandom_range(127, QUEUE_DEPTH + 1));
         3:       lim = LIMIT_BITS'(127);
         4:       lim = LIMIT_BITS'(QUEUE_DEPTH - 1);
         default: lim = LIMIT_BITS'($urandom_range(8, 1));
      endcase
      // upper bits are dropped by the register
      return {9'($urandom_range(511)), lim};
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] pick_interval();
      case ($urandom_range(7))
         0:       return '0;
         1:       return CSR_DATA_BITS'(1);
         2:       return CSR_DATA_BITS'($urandom_range(40, 9));
         default: return CSR_DATA_BITS'($urandom_range(6, 1));
      endcase
   endfunction

   // one random phase: new settings, then a mix of arrivals and ticks
   task automatic random_phase();
      int unsigned count;
      int unsigned arrival_pct;
      bit          burst;
      burst = ($urandom_range(5) == 0);
      if (burst) begin
         set_regs({9'($urandom_range(511)), 7'($urandom_range(127, QUEUE_DEPTH))},
                  16'($urandom_range(3, 1)));
         count       = $urandom_range(90, 70);
         arrival_pct = 95;
      end else begin
         set_regs(pick_limit(), pick_interval());
         count       = $urandom_range(60, 15);
         arrival_pct = $urandom_range(85, 20);
      end
      if ($urandom_range(3) == 0) begin
         write_csr(($urandom_range(1) == 0) ? CSR_SPARE_A : CSR_SPARE_B, 16'($urandom()));
      end
      idling_on = ($urandom_range(7) != 0);
      repeat (count) begin
         send_word(($urandom_range(99) < arrival_pct) ? KIND_ARRIVAL : KIND_TICK, $urandom());
      end
      // drain only when the timer is close to idle
      if (($urandom_range(1) == 0) && (tracker.ticks_left() <= DRAIN_BUDGET)) begin
         drain_timer();
      end
      idling_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_kind       = KIND_ARRIVAL;
      req_packet_tag = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_QUEUE_LIMIT;
      csr_wdata      = '0;
      idling_on      = 1'b1;
      sent_words     = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset settings: tick while idle, two arrivals, dispatch both, disarm
      send_word(KIND_TICK, 32'hFFFF_FFFF);
      send_word(KIND_ARRIVAL, 32'h0000_0000);
      send_word(KIND_ARRIVAL, 32'hFFFF_FFFF);
      drain_timer();
      send_word(KIND_TICK, 32'h0000_0000);

      // zero limit drops everything, zero interval acts as one
      set_regs(16'hFF80, 16'h0000);
      send_word(KIND_ARRIVAL, 32'hA5A5_A5A5);
      send_word(KIND_ARRIVAL, 32'h5A5A_5A5A);
      drain_timer();

      // unknown indexes change nothing
      write_csr(CSR_SPARE_A, 16'hFFFF);
      write_csr(CSR_SPARE_B, 16'hFFFF);
      send_word(KIND_ARRIVAL, 32'h8000_0001);
      drain_timer();

      // small limit: third arrival dropped, arrival while armed
      set_regs(16'h0002, 16'h0002);
      send_word(KIND_ARRIVAL, 32'h0123_4567);
      send_word(KIND_ARRIVAL, 32'h89AB_CDEF);
      send_word(KIND_ARRIVAL, 32'hDEAD_BEEF);
      send_word(KIND_TICK, 32'h0);
      send_word(KIND_ARRIVAL, 32'h7FFF_FFFE);
      drain_timer();

      // long interval, run through without idling
      set_regs(16'h0001, 16'h0041);
      idling_on = 1'b0;
      send_word(KIND_ARRIVAL, 32'hC001_D00D);
      send_word(KIND_ARRIVAL, 32'h0BAD_F00D);
      drain_timer();
      idling_on = 1'b1;

      // random phases
      while (sent_words < WORD_TARGET) begin
         random_phase();
      end

      // short interval so the closing drain stays brief
      set_regs(16'h0040, 16'h0001);
      drain_timer();

      // let the last words come out
      wait_settled();
      repeat (4) @(negedge clock);
      tracker.close_out();
      if (tracker.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

`default_nettype wire
